[src/wti_pkg.sv]
// wti_pkg: shared types and constants of the waypoint track interpolator.
// Used by wti_mdu and waypoint_track_interpolator; no dependencies.
package wti_pkg;

  localparam int unsigned MAX_WAYPOINTS = 16;
  localparam int unsigned AW = $clog2(MAX_WAYPOINTS);
  localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);
  localparam int unsigned TW = 48;
  localparam int unsigned PW = 48;
  localparam int unsigned IDW = 32;
  localparam int unsigned MW = PW + 1;
  localparam int unsigned DW = MW + TW;
  localparam int unsigned STEPS = TW;
  localparam int unsigned SCW = $clog2(STEPS);
  localparam int unsigned VSHIFT = 20;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_WP_ORDER  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_TOO_FEW   = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;
  localparam logic [2:0] ST_PLS_ORDER = 3'd5;
  localparam logic [2:0] ST_ID_OVF    = 3'd6;

  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } mdu_op_e;

  typedef struct packed {
    logic          start;
    mdu_op_e       op;
    logic [DW-1:0] init;
    logic [MW-1:0] opd;
  } mdu_req_t;

  typedef struct packed {
    logic [TW-1:0] t;
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [PW-1:0] z;
  } wti_row_t;

endpackage

[src/wti_mdu.sv]
// wti_mdu: shared bit-serial multiply / restoring divide unit, one bit per cycle.
// Depends on wti_pkg.
module wti_mdu (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wti_pkg::mdu_req_t      req_i,
  output logic                   done_o,
  output logic [wti_pkg::DW-1:0] res_o
);
  import wti_pkg::*;

  logic [DW-1:0]  p_q;
  logic [MW-1:0]  opd_q;
  mdu_op_e        op_q;
  logic           busy_q;
  logic           done_q;
  logic [SCW-1:0] cnt_q;

  logic [MW:0]    sum;
  logic [MW-1:0]  r2;
  logic [MW:0]    diff;
  logic           ge;
  logic [DW-1:0]  p_d;

  always_comb begin
    sum  = {1'b0, p_q[DW-1:TW]} + (p_q[0] ? {1'b0, opd_q} : '0);
    r2   = {p_q[DW-2:TW], p_q[TW-1]};
    diff = {1'b0, r2} - {1'b0, opd_q};
    ge   = !diff[MW];
    unique case (op_q)
      MDU_MUL: p_d = {sum, p_q[TW-1:1]};
      MDU_DIV: p_d = {(ge ? diff[MW-1:0] : r2), p_q[TW-2:0], ge};
      default: p_d = p_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= MDU_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SCW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      p_q   <= req_i.init;
      opd_q <= req_i.opd;
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = p_q;

endmodule

[src/waypoint_track_interpolator.sv]
// waypoint_track_interpolator: top level, command decode, waypoint memory and sequencer.
// Depends on wti_pkg and wti_mdu.
//
// Input channel (in_valid_i / in_stall_o) carries one command per transfer:
// clear, append waypoint or query pulse. Output channel (out_valid_o /
// out_stall_i) returns exactly one result per clear, append or query;
// command 3 is dropped. The starting pulse id is written over the APB port.
// Clear and append finish at the transfer edge: the result is valid the next
// cycle. A query scans the waypoint memory one row per cycle, then per axis
// takes one setup state and three passes of the shared 48-step multiply/divide
// unit (two when the velocity saturates). The block takes one command at a
// time; a new command is taken once the sequencer is idle and the output
// register is free or being drained. While the receiver stalls, the result
// is held in the output register. Reset empties the table, clears the pulse
// state and the starting pulse id; the waypoint memory itself keeps no reset
// value.
module waypoint_track_interpolator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic [wti_pkg::TW-1:0]         event_time_i,
  input  logic signed [wti_pkg::PW-1:0]  in_x_i,
  input  logic signed [wti_pkg::PW-1:0]  in_y_i,
  input  logic signed [wti_pkg::PW-1:0]  in_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_o,
  output logic [wti_pkg::IDW-1:0]        pulse_id_o,
  output logic signed [wti_pkg::PW-1:0]  out_x_o,
  output logic signed [wti_pkg::PW-1:0]  out_y_o,
  output logic signed [wti_pkg::PW-1:0]  out_z_o,
  output logic signed [wti_pkg::PW-1:0]  vel_x_o,
  output logic signed [wti_pkg::PW-1:0]  vel_y_o,
  output logic signed [wti_pkg::PW-1:0]  vel_z_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import wti_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PRIME, S_SCAN, S_AXIS, S_MUL, S_DIVP, S_DIVV, S_OUT
  } state_e;

  state_e         state_q;
  logic [IDW-1:0] first_id_q;
  logic [CW-1:0]  count_q;
  logic [IDW-1:0] pcount_q;
  logic [TW-1:0]  last_pt_q;
  logic           have_q;
  logic [TW-1:0]  first_t_q;
  logic [TW-1:0]  last_t_q;

  wti_row_t       mem_q [MAX_WAYPOINTS];
  wti_row_t       rd_q;
  wti_row_t       prev_q;
  wti_row_t       cur_q;
  logic [AW-1:0]  addr_q;
  logic [AW-1:0]  idx_q;
  logic [TW-1:0]  t_q;
  logic [1:0]     axis_q;

  logic           out_valid_q;
  logic [2:0]     status_q;
  logic [IDW-1:0] id_q;
  logic [PW-1:0]  pos_q [3];
  logic [PW-1:0]  vel_q [3];

  logic           accept;
  logic           out_free;
  logic           out_set;
  logic           wr_en;
  logic [2:0]     app_status;
  logic [2:0]     qry_status;
  logic [IDW:0]   id_sum;
  logic           hit;

  logic [PW-1:0]  p0;
  logic [PW-1:0]  p1;
  logic [MW-1:0]  sdiff;
  logic           neg;
  logic [MW-1:0]  mag;
  logic [TW-1:0]  dt;
  logic [TW-1:0]  el;
  logic           vsat;
  logic [PW-1:0]  lim;
  logic [PW-1:0]  vq;
  logic [PW-1:0]  pos_new;
  logic [PW-1:0]  vel_new;
  logic [PW-1:0]  vel_lim;

  mdu_req_t       mreq;
  logic           mdone;
  logic [DW-1:0]  mres;

  wti_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mdone),
    .res_o  (mres)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == 1'b0) ? first_id_q : '0;

  always_comb begin
    id_sum = {1'b0, first_id_q} + {1'b0, pcount_q};
    if (count_q == CW'(MAX_WAYPOINTS)) begin
      app_status = ST_FULL;
    end else if (count_q != '0 && event_time_i <= last_t_q) begin
      app_status = ST_WP_ORDER;
    end else begin
      app_status = ST_OK;
    end
    priority if (count_q < CW'(2)) begin
      qry_status = ST_TOO_FEW;
    end else if (event_time_i < first_t_q || event_time_i > last_t_q) begin
      qry_status = ST_OUTSIDE;
    end else if (have_q && event_time_i <= last_pt_q) begin
      qry_status = ST_PLS_ORDER;
    end else if ((have_q && pcount_q == '0) || id_sum[IDW]) begin
      qry_status = ST_ID_OVF;
    end else begin
      qry_status = ST_OK;
    end
    wr_en   = accept && cmd_i == CMD_APPEND && app_status == ST_OK;
    out_set = (accept && (cmd_i == CMD_CLEAR || cmd_i == CMD_APPEND ||
                          (cmd_i == CMD_QUERY && qry_status != ST_OK))) ||
              (state_q == S_OUT && out_free);
    hit     = (t_q < rd_q.t) || ({1'b0, idx_q} == count_q - CW'(1));
  end

  always_comb begin
    unique case (axis_q)
      2'd0:    begin p0 = prev_q.x; p1 = cur_q.x; end
      2'd1:    begin p0 = prev_q.y; p1 = cur_q.y; end
      default: begin p0 = prev_q.z; p1 = cur_q.z; end
    endcase
    sdiff   = {p1[PW-1], p1} - {p0[PW-1], p0};
    neg     = sdiff[MW-1];
    mag     = neg ? (MW'(0) - sdiff) : sdiff;
    dt      = cur_q.t - prev_q.t;
    el      = t_q - prev_q.t;
    vsat    = {{(TW - (MW - 28)){1'b0}}, mag[MW-1:28]} >= dt;
    lim     = neg ? {1'b1, {(PW - 1){1'b0}}} : {1'b0, {(PW - 1){1'b1}}};
    vq      = mres[PW-1:0];
    pos_new = p0 + (neg ? (PW'(0) - vq) : vq);
    vel_lim = neg ? (PW'(0) - lim) : lim;
    vel_new = (vq > lim) ? vel_lim : (neg ? (PW'(0) - vq) : vq);

    mreq = '{start: 1'b0, op: MDU_MUL, init: '0, opd: '0};
    unique case (state_q)
      S_AXIS: mreq = '{start: 1'b1, op: MDU_MUL, init: {{MW{1'b0}}, el}, opd: mag};
      S_MUL: begin
        if (mdone) mreq = '{start: 1'b1, op: MDU_DIV, init: mres, opd: {1'b0, dt}};
      end
      S_DIVP: begin
        if (mdone && !vsat) begin
          mreq = '{start: 1'b1, op: MDU_DIV,
                   init: {{(DW - MW - VSHIFT){1'b0}}, mag, {VSHIFT{1'b0}}},
                   opd: {1'b0, dt}};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= '{t: event_time_i, x: in_x_i, y: in_y_i, z: in_z_i};
    end
    rd_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_id_q  <= '0;
      count_q     <= '0;
      pcount_q    <= '0;
      last_pt_q   <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
      idx_q       <= '0;
      axis_q      <= '0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == 1'b0) begin
        first_id_q <= pwdata;
      end
      if (out_valid_q && !out_stall_i && !out_set) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            t_q <= event_time_i;
            unique case (cmd_i)
              CMD_CLEAR: begin
                count_q     <= '0;
                pcount_q    <= '0;
                last_pt_q   <= '0;
                have_q      <= 1'b0;
                out_valid_q <= 1'b1;
                status_q    <= ST_OK;
              end
              CMD_APPEND: begin
                out_valid_q <= 1'b1;
                status_q    <= app_status;
                if (app_status == ST_OK) begin
                  count_q  <= count_q + 1'b1;
                  last_t_q <= event_time_i;
                  if (count_q == '0) first_t_q <= event_time_i;
                end
              end
              CMD_QUERY: begin
                if (qry_status == ST_OK) begin
                  id_q      <= id_sum[IDW-1:0];
                  pcount_q  <= pcount_q + 1'b1;
                  last_pt_q <= event_time_i;
                  have_q    <= 1'b1;
                  addr_q    <= '0;
                  state_q   <= S_PRIME;
                end else begin
                  out_valid_q <= 1'b1;
                  status_q    <= qry_status;
                end
              end
              default: ;
            endcase
            if (cmd_i != CMD_QUERY || qry_status != ST_OK) begin
              id_q     <= '0;
              pos_q[0] <= '0; pos_q[1] <= '0; pos_q[2] <= '0;
              vel_q[0] <= '0; vel_q[1] <= '0; vel_q[2] <= '0;
            end
          end
        end
        S_PRIME: begin
          addr_q  <= addr_q + 1'b1;
          idx_q   <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (idx_q != '0 && hit) begin
            cur_q   <= rd_q;
            axis_q  <= '0;
            state_q <= S_AXIS;
          end else begin
            prev_q <= rd_q;
            idx_q  <= idx_q + 1'b1;
            addr_q <= addr_q + 1'b1;
          end
        end
        S_AXIS: state_q <= S_MUL;
        S_MUL: begin
          if (mdone) state_q <= S_DIVP;
        end
        S_DIVP: begin
          if (mdone) begin
            pos_q[axis_q] <= pos_new;
            if (vsat) begin
              vel_q[axis_q] <= vel_lim;
              axis_q        <= axis_q + 1'b1;
              state_q       <= (axis_q == 2'd2) ? S_OUT : S_AXIS;
            end else begin
              state_q <= S_DIVV;
            end
          end
        end
        S_DIVV: begin
          if (mdone) begin
            vel_q[axis_q] <= vel_new;
            axis_q        <= axis_q + 1'b1;
            state_q       <= (axis_q == 2'd2) ? S_OUT : S_AXIS;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= ST_OK;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign pulse_id_o  = id_q;
  assign out_x_o     = pos_q[0];
  assign out_y_o     = pos_q[1];
  assign out_z_o     = pos_q[2];
  assign vel_x_o     = vel_q[0];
  assign vel_y_o     = vel_q[1];
  assign vel_z_o     = vel_q[2];

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_WAYPOINTS))
    else $error("waypoint count above table size");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdone |-> (state_q == S_MUL || state_q == S_DIVP || state_q == S_DIVV))
    else $error("arithmetic unit finished outside a wait state");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_QUERY && qry_status == ST_OK) |=> state_q == S_PRIME)
    else $error("accepted query did not start the sequencer");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("command taken while sequencer busy");

endmodule

[sim/tb_top.sv]
// tb_top: self-checking testbench for waypoint_track_interpolator.
// Carries its own waypoint table model and checks every result as it is returned.
// Depends on wti_pkg and the waypoint_track_interpolator RTL.
module tb_top;
  import wti_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 520;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] t;
    logic [47:0] x;
    logic [47:0] y;
    logic [47:0] z;
  } track_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic [47:0] px;
    logic [47:0] py;
    logic [47:0] pz;
    logic [47:0] vx;
    logic [47:0] vy;
    logic [47:0] vz;
  } fix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_taken = 1'b0;
  logic out_stall = 1'b0;
  logic calm = 1'b0;
  int in_gap = 0;
  int stall_gap = 0;
  track_cmd_t cur = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;

  logic in_stall_o, out_valid_o, pready;
  logic [2:0] status_o;
  logic [31:0] pulse_id_o, prdata;
  logic [47:0] out_x_o, out_y_o, out_z_o, vel_x_o, vel_y_o, vel_z_o;

  track_cmd_t cmd_q[$];
  fix_t       fix_q[$];
  int n_items = 0;
  int n_err = 0;
  int idle_cycles = 0;

  // track model
  logic [31:0] m_fid = '0;
  logic [47:0] m_t[MAX_WAYPOINTS], m_x[MAX_WAYPOINTS], m_y[MAX_WAYPOINTS], m_z[MAX_WAYPOINTS];
  int          m_cnt = 0;
  logic [31:0] m_pulses = '0;
  logic [47:0] m_last_t = '0;
  logic        m_have = 1'b0;

  waypoint_track_interpolator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o),
    .cmd_i(cur.cmd), .event_time_i(cur.t),
    .in_x_i(cur.x), .in_y_i(cur.y), .in_z_i(cur.z),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .status_o(status_o), .pulse_id_o(pulse_id_o),
    .out_x_o(out_x_o), .out_y_o(out_y_o), .out_z_o(out_z_o),
    .vel_x_o(vel_x_o), .vel_y_o(vel_y_o), .vel_z_o(vel_z_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void lerp_axis(input logic [47:0] a, input logic [47:0] b,
                                    input logic [47:0] el, input logic [47:0] dt,
                                    output logic [47:0] pos, output logic [47:0] vel);
    logic [127:0] p0, diff, mag, off, v, lim, e, d;
    logic neg;
    p0   = {{80{a[47]}}, a};
    diff = {{80{b[47]}}, b} - p0;
    neg  = diff[127];
    mag  = neg ? -diff : diff;
    e    = 128'(el);
    d    = 128'(dt);
    off  = (mag * e) / d;
    v    = (mag << VSHIFT) / d;
    lim  = neg ? 128'h8000_0000_0000 : 128'h7fff_ffff_ffff;
    if (v > lim) v = lim;
    pos = 48'(p0 + (neg ? -off : off));
    vel = 48'(neg ? -v : v);
  endfunction

  task automatic track_step(input track_cmd_t c);
    fix_t r;
    int i, seg;
    logic [47:0] dt, el;
    r = '0;
    case (c.cmd)
      CMD_CLEAR: begin
        m_cnt = 0;
        m_pulses = '0;
        m_last_t = '0;
        m_have = 1'b0;
        fix_q.insert(fix_q.size(), r);
      end
      CMD_APPEND: begin
        if (m_cnt >= MAX_WAYPOINTS) r.status = ST_FULL;
        else if (m_cnt > 0 && c.t <= m_t[m_cnt-1]) r.status = ST_WP_ORDER;
        else begin
          m_t[m_cnt] = c.t; m_x[m_cnt] = c.x; m_y[m_cnt] = c.y; m_z[m_cnt] = c.z;
          m_cnt++;
        end
        fix_q.insert(fix_q.size(), r);
      end
      CMD_QUERY: begin
        if (m_cnt < 2) r.status = ST_TOO_FEW;
        else if (c.t < m_t[0] || c.t > m_t[m_cnt-1]) r.status = ST_OUTSIDE;
        else if (m_have && c.t <= m_last_t) r.status = ST_PLS_ORDER;
        else if ((m_have && m_pulses == 0) || ({1'b0, m_fid} + {1'b0, m_pulses}) > 33'hffff_ffff)
          r.status = ST_ID_OVF;
        else begin
          i = 0;
          while (i < m_cnt && !(c.t < m_t[i])) i++;
          seg = (i >= m_cnt) ? m_cnt - 2 : i - 1;
          dt = m_t[seg+1] - m_t[seg];
          el = c.t - m_t[seg];
          r.id = m_fid + m_pulses;
          lerp_axis(m_x[seg], m_x[seg+1], el, dt, r.px, r.vx);
          lerp_axis(m_y[seg], m_y[seg+1], el, dt, r.py, r.vy);
          lerp_axis(m_z[seg], m_z[seg+1], el, dt, r.pz, r.vz);
          m_pulses = m_pulses + 1;
          m_last_t = c.t;
          m_have = 1'b1;
        end
        fix_q.insert(fix_q.size(), r);
      end
      default: ;
    endcase
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cur <= cmd_q.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (stall_gap > 0) begin
      stall_gap <= stall_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 5) == 0) stall_gap <= $urandom_range(1, 6);
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    fix_t got, want;
    if (rst_ni) begin
      in_taken <= in_valid && !in_stall_o;
      if (in_valid && !in_stall_o) track_step(cur);
      if (out_valid_o && !out_stall) begin
        got = '{status_o, pulse_id_o, out_x_o, out_y_o, out_z_o, vel_x_o, vel_y_o, vel_z_o};
        if (fix_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result: %p", got);
        end else begin
          want = fix_q.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 10) begin
              $display("mismatch: status exp %0d got %0d, id exp %h got %h",
                       want.status, got.status, want.id, got.id);
              $display("  pos exp %h %h %h got %h %h %h",
                       want.px, want.py, want.pz, got.px, got.py, got.pz);
              $display("  vel exp %h %h %h got %h %h %h",
                       want.vx, want.vy, want.vz, got.vx, got.vy, got.vz);
            end
          end
        end
      end
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rnd48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [47:0] rnd_pos();
    int s;
    if ($urandom_range(0, 1) == 0) return rnd48();
    s = $urandom_range(0, 4000) - 2000;
    return 48'(s);
  endfunction

  task automatic push(input logic [1:0] c, input logic [47:0] t,
                      input logic [47:0] x, input logic [47:0] y, input logic [47:0] z);
    cmd_q.insert(cmd_q.size(), track_cmd_t'{c, t, x, y, z});
    if (c != CMD_UNUSED) n_items++;
  endtask

  task automatic gen_track();
    logic [47:0] wt[$];
    logic [48:0] nt;
    logic [47:0] step, lastq, qt, span;
    int n, nq, r;
    if ($urandom_range(0, 9) != 0) push(CMD_CLEAR, rnd48(), rnd48(), rnd48(), rnd48());
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(2, 6);
    nt = ($urandom_range(0, 3) == 0) ? {1'b0, rnd48()} : 49'($urandom_range(0, 1000));
    for (int k = 0; k < n; k++) begin
      if (k > 0) begin
        step = $urandom_range(0, 1) ? 48'($urandom_range(1, 500))
                                    : rnd48() >> $urandom_range(4, 24);
        if ($urandom_range(0, 19) == 0) step = 0;
        nt = nt + step;
        if (nt[48]) nt = 49'hffff_ffff_ffff;
      end
      push(CMD_APPEND, nt[47:0], rnd_pos(), rnd_pos(), rnd_pos());
      if (wt.size() < MAX_WAYPOINTS && (wt.size() == 0 || nt[47:0] > wt[$]))
        wt.insert(wt.size(), nt[47:0]);
    end
    if (wt.size() < 2) return;
    nq = $urandom_range(1, 10);
    lastq = wt[0];
    for (int k = 0; k < nq; k++) begin
      r = $urandom_range(0, 19);
      if (r == 0) qt = $urandom_range(0, 1) ? wt[$] + 1 : wt[0] - 1;
      else if (r == 1) qt = wt[0];
      else if (r == 2) begin
        push(CMD_UNUSED, rnd48(), rnd48(), rnd48(), rnd48());
        continue;
      end else if (r == 3) qt = wt[$urandom_range(0, wt.size() - 1)];
      else begin
        span = wt[$] - lastq;
        qt = (span == 0) ? lastq
                         : 48'(lastq + ((rnd48() % (span + 49'd1)) >> $urandom_range(0, 6)));
        lastq = qt;
      end
      push(CMD_QUERY, qt, rnd48(), rnd48(), rnd48());
    end
  endtask

  task automatic apb_write(input logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    m_fid = v;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (cmd_q.size() > 0 || in_valid || fix_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  localparam logic [47:0] TMAX = 48'hffff_ffff_ffff;
  localparam logic [47:0] PMAX = 48'h7fff_ffff_ffff;
  localparam logic [47:0] PMIN = 48'h8000_0000_0000;

  initial begin
    logic [31:0] fids[4];
    int goal[4];
    fids = '{32'd0, 32'hffff_ffff, $urandom(), 32'hffff_fffe};
    goal = '{300, 480, 700, 900};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      apb_write(fids[p]);
      calm = (p == 3);
      if (p == 0) begin
        push(CMD_CLEAR, 0, 0, 0, 0);
        push(CMD_QUERY, 5, 0, 0, 0);
        push(CMD_APPEND, 100, PMAX, PMIN, 0);
        push(CMD_QUERY, 100, 0, 0, 0);
        push(CMD_APPEND, 100, 1, 1, 1);
        push(CMD_APPEND, 50, 1, 1, 1);
        push(CMD_APPEND, 1100, PMIN, PMAX, TMAX);
        push(CMD_QUERY, 99, 0, 0, 0);
        push(CMD_QUERY, 1101, 0, 0, 0);
        push(CMD_QUERY, 100, 0, 0, 0);
        push(CMD_QUERY, 100, 0, 0, 0);
        push(CMD_QUERY, 600, TMAX, TMAX, TMAX);
        push(CMD_QUERY, 1100, 0, 0, 0);
        push(CMD_APPEND, TMAX, PMAX, 48'd1, PMIN);
        push(CMD_QUERY, 48'h8000_0000_0000, 0, 0, 0);
        push(CMD_QUERY, TMAX, 0, 0, 0);
        push(CMD_UNUSED, TMAX, TMAX, TMAX, TMAX);
        push(CMD_CLEAR, TMAX, TMAX, TMAX, TMAX);
        push(CMD_APPEND, 0, 0, 0, 0);
        push(CMD_APPEND, 1, PMAX, PMIN, PMAX);
        push(CMD_QUERY, 0, 0, 0, 0);
        push(CMD_QUERY, 1, 0, 0, 0);
      end
      while (n_items < goal[p]) gen_track();
    end
    wait_idle();
    if (n_err == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
